// ----- rtl/gray_sobel_edge_stream_unit_defines.svh -----
// Assertion macros for the checker file of the gray Sobel edge unit.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef GRAY_SOBEL_EDGE_STREAM_UNIT_DEFINES_SVH
`define GRAY_SOBEL_EDGE_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define GSE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define GSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gse_pkg.sv -----
// Package of the gray Sobel edge unit: register codes, reset values, types
// and the gray and Sobel arithmetic functions. No dependencies.
`timescale 1ns / 1ps

package gse_pkg;

  localparam int unsigned GSE_MAX_WIDTH  = 2048;
  localparam int unsigned GSE_MAX_HEIGHT = 4096;

  localparam int unsigned LINE_WIDTH_BITS   = 12;
  localparam int unsigned FRAME_HEIGHT_BITS = 13;
  localparam int unsigned WEIGHT_BITS       = 8;
  localparam int unsigned CFG_INDEX_BITS    = 3;
  localparam int unsigned CFG_DATA_BITS     = 13;
  localparam int unsigned PIX_BITS          = 8;
  localparam int unsigned PROD_BITS         = 16;
  localparam int unsigned SUM_BITS          = 18;

  localparam logic [LINE_WIDTH_BITS-1:0]   LINE_WIDTH_RST   = 12'd640;
  localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;
  // 0.2126, 0.7152 and 0.0722 scaled by 255, truncated
  localparam logic [WEIGHT_BITS-1:0]       WEIGHT_FIRST_RST  = 8'd54;
  localparam logic [WEIGHT_BITS-1:0]       WEIGHT_SECOND_RST = 8'd182;
  localparam logic [WEIGHT_BITS-1:0]       WEIGHT_THIRD_RST  = 8'd18;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LINE_WIDTH,
    REG_FRAME_HEIGHT,
    REG_WEIGHT_FIRST,
    REG_WEIGHT_SECOND,
    REG_WEIGHT_THIRD
  } cfg_reg_e;

  typedef logic [PIX_BITS-1:0] pix_t;
  // row r, column c at index r*3 + c; row 0 on top, column 0 on the left
  typedef pix_t [8:0] win_t;

  typedef struct packed {
    logic has_res;
    logic row_end;
    logic frame_end;
  } item_flags_t;

  // x / 255, saturated at 255. Below 255*256 the quotient is exact as
  // (x + (x >> 8) + 1) >> 8 on 16 bits.
  function automatic pix_t gray_div255(input logic [SUM_BITS-1:0] x);
    logic [16:0] t;
    t = 17'(x[15:0]) + 17'(x[15:8]) + 17'd1;
    if (x >= 18'd65280) begin
      return 8'hFF;
    end
    return t[15:8];
  endfunction

  function automatic pix_t sobel_mag(input win_t p);
    logic [9:0]  gxp;
    logic [9:0]  gxn;
    logic [9:0]  gyp;
    logic [9:0]  gyn;
    logic [9:0]  dx;
    logic [9:0]  dy;
    logic [10:0] s;
    gxp = 10'(p[2]) + {1'b0, p[5], 1'b0} + 10'(p[8]);
    gxn = 10'(p[0]) + {1'b0, p[3], 1'b0} + 10'(p[6]);
    gyp = 10'(p[0]) + {1'b0, p[1], 1'b0} + 10'(p[2]);
    gyn = 10'(p[6]) + {1'b0, p[7], 1'b0} + 10'(p[8]);
    dx  = (gxp >= gxn) ? gxp - gxn : gxn - gxp;
    dy  = (gyp >= gyn) ? gyp - gyn : gyn - gyp;
    s   = 11'(dx) + 11'(dy);
    if (s[10:8] != 3'd0) begin
      return 8'hFF;
    end
    return s[7:0];
  endfunction

endpackage

// ----- rtl/gray_sobel_edge_stream_unit.sv -----
// Top level of the gray Sobel edge unit: gray conversion, line store,
// 3x3 window and Sobel output. Depends on gse_pkg and gse_ram.
`timescale 1ns / 1ps

// Usage
// - Input channel: one RGB-style pixel per item (chan_zero/one/two), raster
//   order, taken when in_valid_i is high and in_stall_o is low.
// - Output channel: one item per interior pixel, (height-2) x (width-2) per
//   frame; row_done_o marks the last of an output row, frame_done_o the last
//   of the frame. Taken when out_valid_o is high and out_stall_i is low.
// - Config: cfg_valid_i with cfg_index_i/cfg_data_i; cfg_ready_o is always
//   high. Write only while the unit is idle.
// - Throughput: one item per cycle while the output is not stalled. Input to
//   output: product register and line-store read, window, output register.
// - The line store is one 16-bit wide RAM holding both previous gray rows;
//   it is read when an item is taken and written back one stage later, so a
//   column is never read again before its write lands (width is at least 3).
// - Reset: config returns to 640x480 and the default weights, counters and
//   window clear, pipeline empties. The RAM is not cleared: no output reads an
//   entry before the current frame wrote it.
// - Output stall: stages ahead of the output register keep moving into empty
//   slots; items with no result drop out, so input stalls only when the output
//   register and stage 2 both hold results waiting on the receiver and stage 1
//   is occupied.
module gray_sobel_edge_stream_unit import gse_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = GSE_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = GSE_MAX_HEIGHT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // pixel input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [PIX_BITS-1:0]       chan_zero_i,
  input  logic [PIX_BITS-1:0]       chan_one_i,
  input  logic [PIX_BITS-1:0]       chan_two_i,
  // edge output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [PIX_BITS-1:0]       edge_strength_o,
  output logic                      row_done_o,
  output logic                      frame_done_o,
  // config writes
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XW = (WW > LINE_WIDTH_BITS) ? WW : LINE_WIDTH_BITS;
  localparam int unsigned YW = (HW > FRAME_HEIGHT_BITS) ? HW : FRAME_HEIGHT_BITS;
  localparam int unsigned LW = 2 * PIX_BITS;

  localparam logic [XW-1:0] W_MAX = XW'(MAX_WIDTH);
  localparam logic [YW-1:0] H_MAX = YW'(MAX_HEIGHT);
  localparam logic [XW-1:0] W_MIN = XW'(3);
  localparam logic [YW-1:0] H_MIN = YW'(3);

  // ---------------- configuration ----------------
  logic [LINE_WIDTH_BITS-1:0]   line_width_q;
  logic [FRAME_HEIGHT_BITS-1:0] frame_height_q;
  logic [WEIGHT_BITS-1:0]       weight_first_q;
  logic [WEIGHT_BITS-1:0]       weight_second_q;
  logic [WEIGHT_BITS-1:0]       weight_third_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q    <= LINE_WIDTH_RST;
      frame_height_q  <= FRAME_HEIGHT_RST;
      weight_first_q  <= WEIGHT_FIRST_RST;
      weight_second_q <= WEIGHT_SECOND_RST;
      weight_third_q  <= WEIGHT_THIRD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_LINE_WIDTH:    line_width_q    <= cfg_data_i[LINE_WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i[FRAME_HEIGHT_BITS-1:0];
        REG_WEIGHT_FIRST:  weight_first_q  <= cfg_data_i[WEIGHT_BITS-1:0];
        REG_WEIGHT_SECOND: weight_second_q <= cfg_data_i[WEIGHT_BITS-1:0];
        REG_WEIGHT_THIRD:  weight_third_q  <= cfg_data_i[WEIGHT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective geometry, clamped to the supported range
  logic [XW-1:0] lw_x;
  logic [YW-1:0] fh_y;
  logic [XW-1:0] eff_w;
  logic [YW-1:0] eff_h;

  assign lw_x  = XW'(line_width_q);
  assign fh_y  = YW'(frame_height_q);
  assign eff_w = (lw_x < W_MIN) ? W_MIN : ((lw_x > W_MAX) ? W_MAX : lw_x);
  assign eff_h = (fh_y < H_MIN) ? H_MIN : ((fh_y > H_MAX) ? H_MAX : fh_y);

  // ---------------- pipeline control ----------------
  logic        v1_q, v2_q, vo_q;
  item_flags_t flags1_q, flags2_q;
  logic        accept;
  logic        out_free;
  logic        s2_go, s2_free;
  logic        s1_go, s1_free;

  // a stage moves when the one after it is empty or moving too;
  // items without a result leave stage 2 without using the output slot
  assign out_free   = !vo_q || !out_stall_i;
  assign s2_go      = v2_q && (!flags2_q.has_res || out_free);
  assign s2_free    = !v2_q || s2_go;
  assign s1_go      = v1_q && s2_free;
  assign s1_free    = !v1_q || s1_go;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;

  // ---------------- position counters (advance on accept) ----------------
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [XW-1:0] col_next;
  logic [YW-1:0] row_next;
  logic          last_col, last_row;
  item_flags_t   flags0;

  assign col_next = XW'(col_q) + XW'(1);
  assign row_next = YW'(row_q) + YW'(1);
  assign last_col = (col_next >= eff_w);
  assign last_row = (row_next >= eff_h);

  assign flags0.has_res   = (col_q >= CW'(2)) && (row_q >= RW'(2));
  assign flags0.row_end   = last_col;
  assign flags0.frame_end = last_col && last_row;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_next[RW-1:0];
      end else begin
        col_d = col_next[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- stage 1: channel products, line-store read ----------------
  logic [PROD_BITS-1:0] prod0_q, prod1_q, prod2_q;
  logic [CW-1:0]        col1_q;
  logic [SUM_BITS-1:0]  sum1;
  pix_t                 gray1;
  logic [LW-1:0]        line_rdata;
  pix_t                 top1, mid1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (accept) begin
      v1_q <= 1'b1;
    end else if (s1_go) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod0_q  <= chan_zero_i * weight_first_q;
      prod1_q  <= chan_one_i * weight_second_q;
      prod2_q  <= chan_two_i * weight_third_q;
      col1_q   <= col_q;
      flags1_q <= flags0;
    end
  end

  assign sum1  = SUM_BITS'(prod0_q) + SUM_BITS'(prod1_q) + SUM_BITS'(prod2_q);
  assign gray1 = gray_div255(sum1);
  assign top1  = line_rdata[LW-1:PIX_BITS];
  assign mid1  = line_rdata[PIX_BITS-1:0];

  // upper byte: row two above, lower byte: row just above
  gse_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (col1_q),
    .wdata_i ({mid1, gray1}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  // ---------------- stage 2: window ----------------
  win_t win_q, win_d;

  always_comb begin
    win_d = win_q;
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = top1;
    win_d[5] = mid1;
    win_d[8] = gray1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q     <= 1'b0;
      flags2_q <= '0;
      win_q    <= '0;
    end else if (s1_go) begin
      v2_q     <= 1'b1;
      flags2_q <= flags1_q;
      win_q    <= win_d;
    end else if (s2_go) begin
      v2_q <= 1'b0;
    end
  end

  // ---------------- output register ----------------
  pix_t edge_q;
  logic rowd_q, frmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (s2_go && flags2_q.has_res) begin
      vo_q <= 1'b1;
    end else if (!out_stall_i) begin
      vo_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && flags2_q.has_res) begin
      edge_q <= sobel_mag(win_q);
      rowd_q <= flags2_q.row_end;
      frmd_q <= flags2_q.frame_end;
    end
  end

  assign out_valid_o     = vo_q;
  assign edge_strength_o = edge_q;
  assign row_done_o      = rowd_q;
  assign frame_done_o    = frmd_q;

endmodule

// ----- rtl/gse_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued. No dependencies.
`timescale 1ns / 1ps

module gse_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gse_checker.sv -----
// Port-level checks of the gray Sobel edge unit, bound to the top level.
// Depends on gray_sobel_edge_stream_unit_defines.svh.
`timescale 1ns / 1ps
`include "gray_sobel_edge_stream_unit_defines.svh"

module gse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] edge_strength_o,
  input logic       row_done_o,
  input logic       frame_done_o
);

  // a pending result stays until taken
  `GSE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output item dropped while stalled")

  `GSE_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(edge_strength_o) && $stable(row_done_o) && $stable(frame_done_o), "stalled output item changed")

  // frame end only on a row end
  `GSE_ASSERT(a_frame_row, out_valid_o && frame_done_o, row_done_o, "frame_done without row_done")

  // input is never held off while the output slot is free
  `GSE_ASSERT(a_no_false_stall, !out_valid_o || !out_stall_i, !in_stall_o, "input stalled with free output")

endmodule

bind gray_sobel_edge_stream_unit gse_checker u_gse_checker (.*);
